[rtl/core/rbp_pkg.sv]
`default_nettype none

package rbp_pkg;

  localparam int unsigned CordicStagesDef = 16;

  // 1/gain, Q0.30
  localparam logic [29:0] Invk = 30'd652032874;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic signed [15:0] heading;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic        [7:0]  tag;
  } rot_t;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [33:0] z;
    logic signed [15:0] heading;
    logic        [7:0]  tag;
  } vec_t;

  function automatic logic [31:0] ang_f(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rbp_rot_cell.sv]
`default_nettype none

module rbp_rot_cell #(
  parameter int unsigned Stage = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire rbp_pkg::rot_t data_i,
  output logic             valid_o,
  output rbp_pkg::rot_t    data_o
);

  localparam logic signed [33:0] Ang = $signed({2'b00, rbp_pkg::ang_f(Stage)});

  logic          valid_q;
  rbp_pkg::rot_t data_d, data_q;

  always_comb begin
    data_d = data_i;
    if (data_i.z >= 0) begin
      data_d.x = data_i.x - (data_i.y >>> Stage);
      data_d.y = data_i.y + (data_i.x >>> Stage);
      data_d.z = data_i.z - Ang;
    end else begin
      data_d.x = data_i.x + (data_i.y >>> Stage);
      data_d.y = data_i.y - (data_i.x >>> Stage);
      data_d.z = data_i.z + Ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/core/rbp_vec_cell.sv]
`default_nettype none

module rbp_vec_cell #(
  parameter int unsigned Stage = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire rbp_pkg::vec_t data_i,
  output logic             valid_o,
  output rbp_pkg::vec_t    data_o
);

  localparam logic signed [33:0] Ang = $signed({2'b00, rbp_pkg::ang_f(Stage)});

  logic          valid_q;
  rbp_pkg::vec_t data_d, data_q;

  always_comb begin
    data_d = data_i;
    if (data_i.y >= 0) begin
      data_d.x = data_i.x + (data_i.y >>> Stage);
      data_d.y = data_i.y - (data_i.x >>> Stage);
      data_d.z = data_i.z + Ang;
    end else begin
      data_d.x = data_i.x - (data_i.y >>> Stage);
      data_d.y = data_i.y + (data_i.x >>> Stage);
      data_d.z = data_i.z - Ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/core/range_bearing_prediction.sv]
`default_nettype none

// Range and bearing prediction for a scanner mounted ahead of the robot centre.
// Fully pipelined: one word accepted per cycle while the pipe is not stalled. The
// registers in order are the input stage, rotation CORDIC cells, offset multiply,
// difference, vectoring CORDIC cells, range scaling multiply and output register. The
// whole pipe stalls only while the output word is held by out_ready_i low.
module range_bearing_prediction #(
  parameter int unsigned CORDIC_STAGES = rbp_pkg::CordicStagesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic signed [31:0] scanner_offset_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] robot_heading_i,
  input  wire logic signed [31:0] robot_x_i,
  input  wire logic signed [31:0] robot_y_i,
  input  wire logic signed [31:0] landmark_x_i,
  input  wire logic signed [31:0] landmark_y_i,
  input  wire logic        [7:0]  landmark_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [31:0] predicted_range_o,
  output logic signed      [15:0] predicted_bearing_o,
  output logic             [7:0]  tag_index_o,
  output logic                    range_saturated_o
);

  typedef struct packed {
    logic signed [65:0] px;
    logic signed [65:0] py;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [15:0] heading;
    logic        [7:0]  tag;
  } mul_t;

  typedef struct packed {
    logic        [61:0] p_hi;
    logic        [45:0] p_lo;
    logic        [31:0] z;
    logic signed [15:0] heading;
    logic        [7:0]  tag;
  } rng_t;

  logic adv;
  logic signed [31:0] offset_q;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_we_i) begin
      offset_q <= scanner_offset_i;
    end
  end

  // input stage: start vector for rotation
  rbp_pkg::rot_t rot_d;
  logic          rot_v   [CORDIC_STAGES+1];
  rbp_pkg::rot_t rot_s   [CORDIC_STAGES+1];
  logic          in_v_q;
  rbp_pkg::rot_t in_q;

  always_comb begin
    rot_d.heading = robot_heading_i;
    rot_d.rx      = robot_x_i;
    rot_d.ry      = robot_y_i;
    rot_d.lx      = landmark_x_i;
    rot_d.ly      = landmark_y_i;
    rot_d.tag     = landmark_index_i;
    rot_d.y       = '0;
    rot_d.z       = $signed({{2{robot_heading_i[15]}}, robot_heading_i, 16'h0000});
    rot_d.x       = $signed({4'b0000, rbp_pkg::Invk});
    if (robot_heading_i > 16'sd16384 || robot_heading_i < -16'sd16384) begin
      rot_d.x = -$signed({4'b0000, rbp_pkg::Invk});
      rot_d.z = rot_d.z - (34'sd1 <<< 31);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= rot_d;
    end
  end

  assign rot_v[0] = in_v_q;
  assign rot_s[0] = in_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
    rbp_rot_cell #(.Stage(g)) u_cell (
      .clk_i,
      .rst_ni,
      .en_i    (adv),
      .valid_i (rot_v[g]),
      .data_i  (rot_s[g]),
      .valid_o (rot_v[g+1]),
      .data_o  (rot_s[g+1])
    );
  end

  // offset times cos/sin
  rbp_pkg::rot_t rl;
  logic mul_v_q;
  mul_t mul_q;

  assign rl = rot_s[CORDIC_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else if (adv) begin
      mul_v_q <= rot_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_q.px      <= 66'(offset_q) * 66'(rl.x);
      mul_q.py      <= 66'(offset_q) * 66'(rl.y);
      mul_q.rx      <= rl.rx;
      mul_q.ry      <= rl.ry;
      mul_q.lx      <= rl.lx;
      mul_q.ly      <= rl.ly;
      mul_q.heading <= rl.heading;
      mul_q.tag     <= rl.tag;
    end
  end

  // landmark offset from scanner, prescaled, folded into right half plane
  logic signed [65:0] sx, sy;
  logic signed [37:0] dx, dy;
  logic signed [47:0] x48, y48;
  rbp_pkg::vec_t vec_d;
  logic          vec_v [CORDIC_STAGES+1];
  rbp_pkg::vec_t vec_s [CORDIC_STAGES+1];
  logic          dif_v_q;
  rbp_pkg::vec_t dif_q;

  always_comb begin
    sx  = (mul_q.px + (66'sd1 <<< 29)) >>> 30;
    sy  = (mul_q.py + (66'sd1 <<< 29)) >>> 30;
    dx  = 38'(mul_q.lx) - (38'(mul_q.rx) + 38'(sx));
    dy  = 38'(mul_q.ly) - (38'(mul_q.ry) + 38'(sy));
    x48 = 48'(dx) <<< 8;
    y48 = 48'(dy) <<< 8;
    vec_d.heading = mul_q.heading;
    vec_d.tag     = mul_q.tag;
    vec_d.x       = x48;
    vec_d.y       = y48;
    vec_d.z       = '0;
    if (x48 < 0) begin
      vec_d.x = -x48;
      vec_d.y = -y48;
      vec_d.z = 34'sd1 <<< 31;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dif_v_q <= 1'b0;
    end else if (adv) begin
      dif_v_q <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dif_q <= vec_d;
    end
  end

  assign vec_v[0] = dif_v_q;
  assign vec_s[0] = dif_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
    rbp_vec_cell #(.Stage(g)) u_cell (
      .clk_i,
      .rst_ni,
      .en_i    (adv),
      .valid_i (vec_v[g]),
      .data_i  (vec_s[g]),
      .valid_o (vec_v[g+1]),
      .data_o  (vec_s[g+1])
    );
  end

  // gain correction, split in two partial products
  rbp_pkg::vec_t vl;
  logic rng_v_q;
  rng_t rng_q;

  assign vl = vec_s[CORDIC_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_v_q <= 1'b0;
    end else if (adv) begin
      rng_v_q <= vec_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rng_q.p_hi    <= 62'(vl.x[47:16]) * 62'(rbp_pkg::Invk);
      rng_q.p_lo    <= 46'(vl.x[15:0]) * 46'(rbp_pkg::Invk);
      rng_q.z       <= vl.z[31:0];
      rng_q.heading <= vl.heading;
      rng_q.tag     <= vl.tag;
    end
  end

  logic [63:0] sum;
  logic [31:0] bang;
  logic [31:0] bround;
  logic        sat;

  always_comb begin
    sum    = 64'(rng_q.p_hi) + 64'(32'h0020_0000) + 64'(rng_q.p_lo >> 16);
    sat    = |sum[63:54];
    bang   = rng_q.z - {rng_q.heading, 16'h0000};
    bround = bang + 32'h0000_8000;
  end

  logic out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= rng_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      predicted_range_o   <= sat ? 32'hFFFF_FFFF : sum[53:22];
      predicted_bearing_o <= $signed(bround[31:16]);
      tag_index_o         <= rng_q.tag;
      range_saturated_o   <= sat;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

`default_nettype wire

[rtl/core/rbp_checker.sv]
`default_nettype none

module rbp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] predicted_range_o,
  input wire logic [15:0] predicted_bearing_o,
  input wire logic [7:0]  tag_index_o,
  input wire logic        range_saturated_o
);

  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_saturated_o |-> predicted_range_o == 32'hFFFF_FFFF)
    else $error("saturated range not clamped");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input stalled without output back-pressure");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(predicted_range_o) &&
      $stable(predicted_bearing_o) && $stable(tag_index_o))
    else $error("stalled output word changed");

endmodule

bind range_bearing_prediction rbp_checker u_rbp_checker (
  .clk_i,
  .rst_ni,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .predicted_range_o,
  .predicted_bearing_o,
  .tag_index_o,
  .range_saturated_o
);

`default_nettype wire

[tb/sv/range_bearing_prediction_test.sv]
`default_nettype none

module range_bearing_prediction_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSTAGE = rbp_pkg::CordicStagesDef;
  localparam longint INV_GAIN = 64'sd652032874;
  localparam int unsigned WATCHDOG_MAX = 5000;
  localparam int unsigned DRAIN_CYCLES = 2 * NSTAGE + 20;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct {
    logic signed [15:0] hd;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic        [7:0]  idx;
  } pose_word_t;

  typedef struct {
    logic        [31:0] rng;
    logic signed [15:0] brg;
    logic        [7:0]  tag;
    logic               sat;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic signed [31:0] scanner_offset_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] robot_heading_i = '0;
  logic signed [31:0] robot_x_i = '0;
  logic signed [31:0] robot_y_i = '0;
  logic signed [31:0] landmark_x_i = '0;
  logic signed [31:0] landmark_y_i = '0;
  logic [7:0] landmark_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [31:0] predicted_range_o;
  logic signed [15:0] predicted_bearing_o;
  logic [7:0] tag_index_o;
  logic range_saturated_o;

  pose_word_t pending_poses [$];
  reading_t   expected_readings [$];
  longint     offset_q = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatches = 0;
  int unsigned quiet_cycles = 0;

  range_bearing_prediction u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .scanner_offset_i   (scanner_offset_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .robot_heading_i    (robot_heading_i),
    .robot_x_i          (robot_x_i),
    .robot_y_i          (robot_y_i),
    .landmark_x_i       (landmark_x_i),
    .landmark_y_i       (landmark_y_i),
    .landmark_index_i   (landmark_index_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .predicted_range_o  (predicted_range_o),
    .predicted_bearing_o(predicted_bearing_o),
    .tag_index_o        (tag_index_o),
    .range_saturated_o  (range_saturated_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic reading_t predict_reading(pose_word_t p, longint ofs);
    reading_t r;
    longint hz, x, y, z, t, dx, dy;
    longint unsigned ux, hi, lo, rng, b;
    hz = longint'(p.hd) * 65536;
    x = INV_GAIN;
    y = 0;
    z = hz;
    if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
      x = -INV_GAIN;
      z = z - (64'sd1 <<< 31);
    end
    for (int i = 0; i < NSTAGE && i < 32; i++) begin
      t = x;
      if (z >= 0) begin
        x = x - (y >>> i); y = y + (t >>> i); z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + (y >>> i); y = y - (t >>> i); z = z + longint'(ATAN_TAB[i]);
      end
    end
    dx = longint'(p.lx) - (longint'(p.rx) + ((ofs * x + (64'sd1 <<< 29)) >>> 30));
    dy = longint'(p.ly) - (longint'(p.ry) + ((ofs * y + (64'sd1 <<< 29)) >>> 30));
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y;
      z = 64'sd1 <<< 31;
    end
    for (int i = 0; i < NSTAGE && i < 32; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> i); y = y - (t >>> i); z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - (y >>> i); y = y + (t >>> i); z = z - longint'(ATAN_TAB[i]);
      end
    end
    ux = x;
    hi = ux >> 16;
    lo = ux & 64'hFFFF;
    rng = (hi * 64'd652032874 + (64'd1 << 21) + ((lo * 64'd652032874) >> 16)) >> 22;
    r.sat = 1'b0;
    if (rng > 64'hFFFFFFFF) begin
      rng = 64'hFFFFFFFF;
      r.sat = 1'b1;
    end
    b = (z - hz) & 64'hFFFFFFFF;
    r.rng = rng[31:0];
    r.brg = 16'(((b + 64'h8000) >> 16) & 64'hFFFF);
    r.tag = p.idx;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    pose_word_t p;
    logic held;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      held = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        p.hd = robot_heading_i; p.rx = robot_x_i; p.ry = robot_y_i;
        p.lx = landmark_x_i; p.ly = landmark_y_i; p.idx = landmark_index_i;
        expected_readings.push_back(predict_reading(p, offset_q));
        held = 1'b0;
      end
      if (!held) begin
        if (pending_poses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          p = pending_poses.pop_front();
          robot_heading_i <= p.hd;
          robot_x_i <= p.rx;
          robot_y_i <= p.ry;
          landmark_x_i <= p.lx;
          landmark_y_i <= p.ly;
          landmark_index_i <= p.idx;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected word", predicted_range_o, 0);
        end else begin
          w = expected_readings.pop_front();
          if (predicted_range_o !== w.rng) report_mismatch("range", predicted_range_o, w.rng);
          if (predicted_bearing_o !== w.brg)
            report_mismatch("bearing", predicted_bearing_o, w.brg);
          if (tag_index_o !== w.tag) report_mismatch("tag", tag_index_o, w.tag);
          if (range_saturated_o !== w.sat)
            report_mismatch("saturated", range_saturated_o, w.sat);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("** range_bearing_prediction: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] pick_coord(int sel, logic [31:0] near);
    case (sel)
      0: return $urandom;
      1: return near + 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      2: return near;
      default: return near + 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
    endcase
  endfunction

  task automatic queue_pose(input logic [15:0] hd, input logic [31:0] rx, input logic [31:0] ry,
                            input logic [31:0] lx, input logic [31:0] ly, input logic [7:0] idx);
    pose_word_t p;
    p.hd = hd; p.rx = rx; p.ry = ry; p.lx = lx; p.ly = ly; p.idx = idx;
    pending_poses.push_back(p);
  endtask

  task automatic queue_random(input int n);
    logic [31:0] rx, ry;
    int sel;
    for (int k = 0; k < n; k++) begin
      rx = $urandom;
      ry = $urandom;
      if ($urandom_range(3) == 0) begin
        rx = rx >>> 8; ry = ry >>> 8;
      end
      sel = $urandom_range(0, 5);
      queue_pose(16'($urandom), rx, ry, pick_coord(sel, rx), pick_coord(sel, ry),
                 8'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (pending_poses.size() > 0 || in_valid_i || expected_readings.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    scanner_offset_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    offset_q = longint'(signed'(v));
  endtask

  initial begin
    logic [31:0] offsets [5];
    offsets = '{32'h0001_8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0};
    offsets[4] = $urandom;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: heading extremes, quadrant edges, landmark on scanner, saturation
    queue_pose(16'sh0000, 32'h0, 32'h0, 32'h0, 32'h0, 8'h00);
    queue_pose(16'sh8000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 8'hFF);
    queue_pose(16'sh7FFF, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 8'h01);
    queue_pose(16'sh4000, 32'h1000, 32'h2000, 32'h1000, 32'h2000, 8'h80);
    queue_pose(16'sh4001, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 8'h7F);
    queue_pose(16'shC000, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 8'h02);
    queue_pose(16'shBFFF, 32'h0, 32'h0, 32'hFFFF_0000, 32'hFFFF_0000, 8'h03);
    queue_pose(16'sh1234, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h04);
    queue_pose(16'sh0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 8'h05);
    queue_pose(16'sh0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 8'h06);
    queue_pose(16'sh0000, 32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 8'h07);
    queue_pose(16'shFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'h08);
    queue_pose(16'sh0001, 32'h0, 32'h0, 32'h0, 32'h1, 8'h09);
    queue_pose(16'sh0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 8'h0A);
    queue_pose(16'sh2000, 32'h0003_0000, 32'h0, 32'h0, 32'h0003_0000, 8'h0B);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      write_offset(offsets[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 48; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 48; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      // landmark on the scanner itself when there is no offset
      if (offsets[ph] == 0) queue_pose(16'($urandom), 32'h1234_5678, 32'hEDCB_A987,
                                       32'h1234_5678, 32'hEDCB_A987, 8'($urandom));
      queue_random(206);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("** range_bearing_prediction: PASSED **");
    end else begin
      $display("** range_bearing_prediction: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
